/* hw/rtl/lgse_pkg.sv */
// ----------------------------------------------------------------------------
// lgse_pkg
// shared types, constants and helpers of the light grid splat engine
// ----------------------------------------------------------------------------
package lgse_pkg;

  localparam int MAX_GRID_SIDE_DEF = 64;
  localparam int SIDE_W = 9;
  localparam int XY_W = 6;
  localparam int COL_W = 8;
  localparam int LV_W = 9;
  localparam int SB_W = 16;
  localparam int WGT_W = 14;
  localparam logic [6:0] GRID_RESET = 7'd64;

  typedef enum logic [2:0] {
    OP_MARK_CHG = 3'd0,
    OP_MARK_CTR = 3'd1,
    OP_SPLAT    = 3'd2,
    OP_FINISH   = 3'd3,
    OP_READ     = 3'd4
  } op_t;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0]             op;
    logic                   in_grid;
    logic [XY_W-1:0]        x;
    logic [XY_W-1:0]        y;
    logic [COL_W-1:0]       red;
    logic [COL_W-1:0]       green;
    logic [COL_W-1:0]       blue;
    logic [LV_W-1:0]        lv;
    logic signed [SB_W-1:0] sb;
    logic [SIDE_W-1:0]      gw;
    logic [SIDE_W-1:0]      gh;
  } cmd_t;

  function automatic logic [WGT_W-1:0] kernel_weight(input logic [2:0] kx,
                                                     input logic [2:0] ky);
    logic [1:0] dx;
    logic [1:0] dy;
    logic [WGT_W-1:0] w;
    dx = (kx > 3'd2) ? 2'(kx - 3'd2) : 2'(3'd2 - kx);
    dy = (ky > 3'd2) ? 2'(ky - 3'd2) : 2'(3'd2 - ky);
    unique case ({dy, dx})
      4'b0000: w = 14'd8192;
      4'b0001, 4'b0100: w = 14'd4096;
      4'b0101: w = 14'd3276;
      4'b0010, 4'b1000: w = 14'd2048;
      4'b0110, 4'b1001: w = 14'd1638;
      4'b1010: w = 14'd819;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/lgse_front.sv */
// ----------------------------------------------------------------------------
// lgse_front
// accepts transactions, bounds-checks the cell and derives light and bias
// ----------------------------------------------------------------------------
module lgse_front #(
  parameter int MAX_GRID_SIDE = lgse_pkg::MAX_GRID_SIDE_DEF
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic [5:0]         in_cell_x,
  input  logic [5:0]         in_cell_y,
  input  logic [7:0]         in_light_red,
  input  logic [7:0]         in_light_green,
  input  logic [7:0]         in_light_blue,
  input  logic [7:0]         in_light_level,
  input  logic signed [15:0] in_region_height,
  input  logic               in_ceiling_is_sky,
  input  logic               in_floor_is_sky,
  input  logic [6:0]         grid_width,
  input  logic [6:0]         grid_height,
  input  logic               hold,
  input  logic               q_full,
  output logic               q_push,
  output lgse_pkg::cmd_t     q_cmd
);
  import lgse_pkg::*;

  function automatic logic [SIDE_W-1:0] eff_side(input logic [6:0] r);
    logic [SIDE_W-1:0] v;
    v = SIDE_W'(r);
    if (v == '0) v = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_GRID_SIDE)) v = SIDE_W'(MAX_GRID_SIDE);
    return v;
  endfunction

  logic [SIDE_W-1:0] gw;
  logic [SIDE_W-1:0] gh;
  logic [8:0]        lv2;
  logic [16:0]       habs;
  logic [33:0]       hprod;
  logic signed [SB_W-1:0] q6;
  logic signed [SB_W-1:0] hm;
  logic signed [SB_W-1:0] sb;

  always_comb begin
    gw = eff_side(grid_width);
    gh = eff_side(grid_height);
    lv2 = {in_light_level, 1'b0};
    habs = in_region_height[15] ? 17'(-$signed({in_region_height[15], in_region_height}))
                                : 17'({1'b0, in_region_height});
    hprod = 34'(habs) * 34'd43691;
    q6 = SB_W'(hprod >> 18);
    hm = in_region_height - 16'sd100;
    if (in_ceiling_is_sky) begin
      sb = (in_region_height > 16'sd0) ? -q6 : q6;
    end else if (in_floor_is_sky) begin
      sb = (in_region_height > 16'sd0) ? q6 : -q6;
    end else if (in_region_height > 16'sd100) begin
      sb = hm >>> 1;
    end else begin
      sb = '0;
    end
  end

  assign in_ready = !q_full && !hold;
  assign q_push = in_valid && in_ready;

  always_comb begin
    q_cmd.op = in_operation;
    q_cmd.in_grid = (SIDE_W'(in_cell_x) < gw) && (SIDE_W'(in_cell_y) < gh);
    q_cmd.x = in_cell_x;
    q_cmd.y = in_cell_y;
    q_cmd.red = in_light_red;
    q_cmd.green = in_light_green;
    q_cmd.blue = in_light_blue;
    q_cmd.lv = (lv2 > 9'd240) ? 9'(lv2 - 9'd240) : '0;
    q_cmd.sb = sb;
    q_cmd.gw = gw;
    q_cmd.gh = gh;
  end

endmodule

/* hw/rtl/lgse_queue.sv */
// ----------------------------------------------------------------------------
// lgse_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module lgse_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lgse_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output lgse_pkg::cmd_t pop_cmd
);
  import lgse_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hw/rtl/lgse_back.sv */
// ----------------------------------------------------------------------------
// lgse_back
// cell stores, clear and finish sweeps, pipelined splat and read reply
// ----------------------------------------------------------------------------
module lgse_back #(
  parameter int MAX_GRID_SIDE = lgse_pkg::MAX_GRID_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  lgse_pkg::cmd_t    q_cmd,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_cell_red,
  output logic [7:0]        out_cell_green,
  output logic [7:0]        out_cell_blue,
  output logic signed [7:0] out_cell_bias
);
  import lgse_pkg::*;

  localparam int CELLS = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int ADDR_W = $clog2(CELLS);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_CHECK = 9'b000000100,
    ST_EVAL  = 9'b000001000,
    ST_ISSUE = 9'b000010000,
    ST_DRAIN = 9'b000100000,
    ST_SWEEP = 9'b001000000,
    ST_READ  = 9'b010000000,
    ST_REPLY = 9'b100000000
  } state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [9:0] yy,
                                                  input logic [9:0] xx);
    return ADDR_W'(20'(yy) * 20'(MAX_GRID_SIDE) + 20'(xx));
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] old, input logic [7:0] col,
                                         input logic [5:0] lw);
    logic [13:0] prod;
    logic [13:0] t;
    logic [8:0]  s;
    prod = 14'(col) * 14'(lw);
    t = prod + (prod >> 8) + 14'd1;
    s = 9'(old) + 9'(t >> 8);
    return (s > 9'd255) ? 8'd255 : s[7:0];
  endfunction

  logic [23:0]       color_mem [CELLS];
  logic [7:0]        bias_mem [CELLS];
  logic              chg_mem [CELLS];
  logic              ctr_mem [CELLS];

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [ADDR_W-1:0] cnt_r;
  logic [2:0]        kx_r, ky_r;

  logic [23:0]       color_q;
  logic signed [7:0] bias_q;
  logic              chg_q;
  logic              ctr_q;

  logic              p1_v_r;
  logic [WGT_W-1:0]  p1_w_r;
  logic [ADDR_W-1:0] p1_addr_r;
  logic              p2_v_r;
  logic [ADDR_W-1:0] p2_addr_r;
  logic [5:0]        p2_lw_r;
  logic [23:0]       p2_col_r;
  logic signed [25:0] p2_pa_r;
  logic signed [29:0] p2_pb_r;

  logic              out_valid_r;
  logic [7:0]        out_red_r, out_green_r, out_blue_r;
  logic signed [7:0] out_bias_r;

  logic signed [9:0] nx, ny;
  logic              n_in;
  logic [ADDR_W-1:0] rd_addr, ctr_addr, q_addr;
  logic [22:0]       lwp;
  logic [5:0]        lw;
  logic [16:0]       inv_w;
  logic signed [25:0] pa;
  logic signed [29:0] pb;
  logic signed [31:0] acc;
  logic signed [15:0] dv;
  logic signed [7:0] nb;
  logic [23:0]       ncol;
  logic              reply_load;
  logic              sweep_last;

  logic              color_we, bias_we, chg_we, ctr_we;
  logic [ADDR_W-1:0] color_wa, bias_wa, chg_wa, ctr_wa;
  logic [23:0]       color_wd;
  logic [7:0]        bias_wd;
  logic              chg_wd, ctr_wd;

  // neighbor walk
  always_comb begin
    nx = $signed({4'b0, cmd_r.x}) + $signed({7'b0, kx_r}) - 10'sd2;
    ny = $signed({4'b0, cmd_r.y}) + $signed({7'b0, ky_r}) - 10'sd2;
    n_in = (nx >= 10'sd0) && (ny >= 10'sd0)
        && (nx < $signed({1'b0, cmd_r.gw})) && (ny < $signed({1'b0, cmd_r.gh}));
    q_addr = cell_addr({4'b0, q_cmd.y}, {4'b0, q_cmd.x});
    ctr_addr = cell_addr({4'b0, cmd_r.y}, {4'b0, cmd_r.x});
    rd_addr = (state_r == ST_ISSUE) ? cell_addr(ny, nx) : ctr_addr;
  end

  // stage one: weighted level and bias products
  always_comb begin
    lwp = 23'(cmd_r.lv) * 23'(p1_w_r);
    lw = lwp[21:16];
    inv_w = 17'h10000 - 17'(p1_w_r);
    pa = bias_q * $signed({1'b0, inv_w});
    pb = $signed(cmd_r.sb) * $signed({1'b0, p1_w_r});
  end

  // stage two: color saturation and bias mix
  always_comb begin
    acc = p2_pa_r + p2_pb_r;
    dv = (acc < 32'sd0) ? 16'((acc + 32'sd65535) >>> 16) : 16'(acc >>> 16);
    if (dv > 16'sd127) nb = 8'sd127;
    else if (dv < -16'sd128) nb = -8'sd128;
    else nb = dv[7:0];
    ncol = {sat_add(p2_col_r[23:16], cmd_r.red, p2_lw_r),
            sat_add(p2_col_r[15:8], cmd_r.green, p2_lw_r),
            sat_add(p2_col_r[7:0], cmd_r.blue, p2_lw_r)};
  end

  assign q_pop = (state_r == ST_IDLE) && q_valid;
  assign clearing = (state_r == ST_CLEAR);
  assign sweep_last = (cnt_r == ADDR_W'(CELLS - 1));
  assign reply_load = (state_r == ST_REPLY) && (!out_valid_r || out_ready);

  // store write ports
  always_comb begin
    color_we = 1'b0; color_wa = cnt_r; color_wd = '0;
    bias_we = 1'b0;  bias_wa = cnt_r;  bias_wd = '0;
    chg_we = 1'b0;   chg_wa = cnt_r;   chg_wd = 1'b0;
    ctr_we = 1'b0;   ctr_wa = cnt_r;   ctr_wd = 1'b0;
    if (state_r == ST_CLEAR) begin
      color_we = 1'b1;
      bias_we = 1'b1;
      chg_we = 1'b1;
      ctr_we = 1'b1;
    end else if (state_r == ST_SWEEP) begin
      chg_we = 1'b1;
      ctr_we = 1'b1;
    end else if (q_pop && q_cmd.in_grid && (q_cmd.op == OP_MARK_CHG)) begin
      color_we = 1'b1; color_wa = q_addr;
      chg_we = 1'b1;   chg_wa = q_addr; chg_wd = 1'b1;
      ctr_we = 1'b1;   ctr_wa = q_addr; ctr_wd = 1'b1;
    end else if (q_pop && q_cmd.in_grid && (q_cmd.op == OP_MARK_CTR)) begin
      ctr_we = 1'b1;   ctr_wa = q_addr; ctr_wd = 1'b1;
    end else if (p2_v_r) begin
      color_we = 1'b1; color_wa = p2_addr_r; color_wd = ncol;
      bias_we = 1'b1;  bias_wa = p2_addr_r;  bias_wd = nb;
    end
  end

  always_ff @(posedge clk) begin
    if (color_we) color_mem[color_wa] <= color_wd;
    color_q <= color_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (bias_we) bias_mem[bias_wa] <= bias_wd;
    bias_q <= bias_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (chg_we) chg_mem[chg_wa] <= chg_wd;
    chg_q <= chg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctr_we) ctr_mem[ctr_wa] <= ctr_wd;
    ctr_q <= ctr_mem[ctr_addr];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sweep_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (q_pop) begin
          priority if (q_cmd.op == OP_SPLAT && q_cmd.in_grid) state_nxt = ST_CHECK;
          else if (q_cmd.op == OP_FINISH) state_nxt = ST_SWEEP;
          else if (q_cmd.op == OP_READ) state_nxt = ST_READ;
          else state_nxt = ST_IDLE;
        end
      end
      ST_CHECK: state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ctr_q ? ST_ISSUE : ST_IDLE;
      ST_ISSUE: if (kx_r == 3'd4 && ky_r == 3'd4) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!p1_v_r && !p2_v_r) state_nxt = ST_IDLE;
      ST_SWEEP: if (sweep_last) state_nxt = ST_IDLE;
      ST_READ: state_nxt = ST_REPLY;
      ST_REPLY: if (reply_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r <= '0;
      kx_r <= '0;
      ky_r <= '0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR || state_r == ST_SWEEP) cnt_r <= cnt_r + ADDR_W'(1);
      else cnt_r <= '0;
      if (state_r == ST_ISSUE) begin
        if (kx_r == 3'd4) begin
          kx_r <= '0;
          ky_r <= ky_r + 3'd1;
        end else begin
          kx_r <= kx_r + 3'd1;
        end
      end else begin
        kx_r <= '0;
        ky_r <= '0;
      end
      p1_v_r <= (state_r == ST_ISSUE) && n_in;
      p2_v_r <= p1_v_r && chg_q && (lw != '0);
      if (reply_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
    p1_w_r <= kernel_weight(kx_r, ky_r);
    p1_addr_r <= rd_addr;
    p2_addr_r <= p1_addr_r;
    p2_lw_r <= lw;
    p2_col_r <= color_q;
    p2_pa_r <= pa;
    p2_pb_r <= pb;
    if (reply_load) begin
      out_red_r <= cmd_r.in_grid ? color_q[23:16] : '0;
      out_green_r <= cmd_r.in_grid ? color_q[15:8] : '0;
      out_blue_r <= cmd_r.in_grid ? color_q[7:0] : '0;
      out_bias_r <= cmd_r.in_grid ? bias_q : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_cell_red = out_red_r;
  assign out_cell_green = out_green_r;
  assign out_cell_blue = out_blue_r;
  assign out_cell_bias = out_bias_r;

endmodule

/* hw/rtl/light_grid_splat_engine_core.sv */
// ----------------------------------------------------------------------------
// light_grid_splat_engine_core
// grid of light cells with mark, splat, finish and read transactions
// ----------------------------------------------------------------------------
// Input channel (in_*) takes one transaction per handshake; only a read
// returns a transaction on the out_* channel. Grid size is set through the
// APB port (width at 0x0, height at 0x4); the user sets it only while the
// block is idle, which the block itself does not enforce. A front stage
// bounds-checks the cell and derives light level and source bias, a
// two-entry queue decouples it from the back end, which owns the cell
// stores (one write and one read port each, read data registered). A
// splat checks the center cell, issues 25 neighbor reads one per cycle,
// then drains the pipeline; finish sweeps the flags of all MAX_GRID_SIDE^2
// cells. After reset the back end clears all MAX_GRID_SIDE^2 cells (4096
// by default) of every store with in_ready low. A stalled receiver holds
// the read result in the output register; the front keeps accepting until
// the queue is full.
// ----------------------------------------------------------------------------
module light_grid_splat_engine_core #(
  parameter int MAX_GRID_SIDE = lgse_pkg::MAX_GRID_SIDE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic [5:0]         in_cell_x,
  input  logic [5:0]         in_cell_y,
  input  logic [7:0]         in_light_red,
  input  logic [7:0]         in_light_green,
  input  logic [7:0]         in_light_blue,
  input  logic [7:0]         in_light_level,
  input  logic signed [15:0] in_region_height,
  input  logic               in_ceiling_is_sky,
  input  logic               in_floor_is_sky,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_cell_red,
  output logic [7:0]         out_cell_green,
  output logic [7:0]         out_cell_blue,
  output logic signed [7:0]  out_cell_bias,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lgse_pkg::*;

  logic [6:0] grid_width_r;
  logic [6:0] grid_height_r;
  logic       clearing;
  logic       q_full, q_push, q_pop, q_valid;
  cmd_t       push_cmd, pop_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(grid_height_r) : 32'(grid_width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= GRID_RESET;
      grid_height_r <= GRID_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_WIDTH) grid_width_r <= pwdata[6:0];
      else grid_height_r <= pwdata[6:0];
    end
  end

  lgse_front #(.MAX_GRID_SIDE(MAX_GRID_SIDE)) u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_cell_x         (in_cell_x),
    .in_cell_y         (in_cell_y),
    .in_light_red      (in_light_red),
    .in_light_green    (in_light_green),
    .in_light_blue     (in_light_blue),
    .in_light_level    (in_light_level),
    .in_region_height  (in_region_height),
    .in_ceiling_is_sky (in_ceiling_is_sky),
    .in_floor_is_sky   (in_floor_is_sky),
    .grid_width        (grid_width_r),
    .grid_height       (grid_height_r),
    .hold              (clearing),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (push_cmd)
  );

  lgse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  lgse_back #(.MAX_GRID_SIDE(MAX_GRID_SIDE)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_cmd          (pop_cmd),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_red   (out_cell_red),
    .out_cell_green (out_cell_green),
    .out_cell_blue  (out_cell_blue),
    .out_cell_bias  (out_cell_bias)
  );

endmodule
